// ===== design/mpsp_pkg.sv =====
// Package for the multichannel PCM sample player core.
// Holds command codes, register indexes, widths and the controller/datapath interface.
// No dependencies.
`default_nettype none
package mpsp_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE    = 2'd0,
      CMD_READ     = 2'd1,
      CMD_TICK     = 2'd2,
      CMD_ROM_LOAD = 2'd3
   } cmd_type;

   localparam logic [2:0] CFG_DISCRETE   = 3'd0;
   localparam logic [2:0] CFG_BANK_SHIFT = 3'd1;
   localparam logic [2:0] CFG_BANK_MASK  = 3'd2;
   localparam logic [2:0] CFG_RATE_MUL   = 3'd3;
   localparam logic [2:0] CFG_RATE_DIV   = 3'd4;
   localparam logic [2:0] CFG_ROM_SIZE   = 3'd5;
   localparam logic [2:0] CFG_MIX_GAIN   = 3'd6;

   localparam logic KIND_READ   = 1'b0;
   localparam logic KIND_STEREO = 1'b1;

   localparam int CSR_W  = 21;
   localparam int REQ_W  = 80;
   localparam int RSP_W  = 40;
   localparam int DIVD_W = 40;
   localparam int ACC_W  = 24;

   typedef struct packed {
      logic latch_req;
      logic do_write;
      logic rom_load;
      logic rd_issue;
      logic rd_load;
      logic tick_init;
      logic voice_next;
      logic voice_stop;
      logic voice_reload;
      logic addr_calc;
      logic rom_rd_direct;
      logic rom_rd_mod;
      logic sample_zero;
      logic sample_load;
      logic div_start_mod;
      logic div_start_rate;
      logic mul_vol;
      logic mul_gain;
      logic acc_add;
      logic frac_sum;
      logic div_finish;
      logic wr_pos_lo;
      logic wr_pos_hi;
      logic tick_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic voices_done;
      logic stopped;
      logic end_hit;
      logic stop_at_end;
      logic in_range;
      logic discrete;
      logic size_zero;
      logic div_done;
      logic div_busy;
      logic out_free;
   } ctl_stat_type;

endpackage
`default_nettype wire

// ===== design/multichannel_pcm_sample_player_core.sv =====
// Top level of the multichannel PCM sample player: controller plus datapath.
// Depends on mpsp_pkg, mpsp_controller and mpsp_datapath.
//
//   Channel  Direction  Beat contents
//   req_     in         tuser: cmd; tdata: address, data, ROM index/byte, mix left/right
//   rsp_     out        tuser: kind; tdata: read data, left, right
//   csr_     in         write enable, register index, write data
//
// A tick walks the voices in turn: a stopped voice is skipped, and a playing voice waits on the
// 40-step shared divider for its rate step, and once more for the modulo when a banked fetch wraps.
// With a ROM size of zero a tick skips the voice walk.
// Reset takes effect at once; the register RAM uses valid bits, so there is no clearing pass.
// A finished result waits in the output register; a stalled result holds the next read or tick.
`default_nettype none
module multichannel_pcm_sample_player_core #(
   parameter int MAX_VOICES    = 16,
   parameter int ROM_ADDR_BITS = 20
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // tuser: cmd[1:0]
   input  wire logic [1:0]                 req_tuser,
   // tdata: reg_addr[7:0], reg_data[15:8], rom_index[35:16], rom_byte[43:36],
   // mix_in_left[59:44], mix_in_right[75:60], zero fill[79:76]
   input  wire logic [mpsp_pkg::REQ_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // tuser: out_kind[0]
   output logic                            rsp_tuser,
   // tdata: read_data[7:0], left_out[23:8], right_out[39:24]
   output logic      [mpsp_pkg::RSP_W-1:0] rsp_tdata,
   input  wire logic                       csr_we,
   input  wire logic [2:0]                 csr_index,
   input  wire logic [mpsp_pkg::CSR_W-1:0] csr_wdata
);
   import mpsp_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   mpsp_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   mpsp_datapath #(.MAX_VOICES(MAX_VOICES), .ROM_ADDR_BITS(ROM_ADDR_BITS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_load || cmd.tick_load) |-> stat.out_free)
      else $error("result loaded while output register is occupied");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted twice in a row");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_start_mod || cmd.div_start_rate) |-> !stat.div_busy)
      else $error("divider restarted while busy");

   a_load_not_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_load || cmd.tick_load) |-> !req_tready)
      else $error("result loaded while the controller is idle");
endmodule
`default_nettype wire

// ===== design/mpsp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mpsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

// ===== design/mpsp_divider.sv =====
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// No dependencies.
`default_nettype none
module mpsp_divider #(
   parameter int DVD_W = 40,
   parameter int DVS_W = 21
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic      [DVD_W-1:0] quotient,
   output logic      [DVS_W-1:0] remainder,
   output logic                  busy,
   output logic                  done
);
   localparam int CNT_W = $clog2(DVD_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

   logic [DVD_W-1:0] qd_ff;
   logic [DVS_W-1:0] rem_ff, rem_in, dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DVS_W:0]   trial, diff;
   logic             fit;

   always_comb begin
      trial  = {rem_ff, qd_ff[DVD_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      fit    = trial >= {1'b0, dvs_ff};
      rem_in = fit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            qd_ff   <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            qd_ff  <= {qd_ff[DVD_W-2:0], fit};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient  = qd_ff;
   assign remainder = rem_ff;
   assign busy      = busy_ff;
   assign done      = done_ff;
endmodule
`default_nettype wire

// ===== design/mpsp_datapath.sv =====
// Datapath: configuration, voice state, register and sample RAMs, mixer and result register.
// Depends on mpsp_pkg, mpsp_ram and mpsp_divider.
`default_nettype none
module mpsp_datapath #(
   parameter int MAX_VOICES    = 16,
   parameter int ROM_ADDR_BITS = 20
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [2:0]                   csr_index,
   input  wire logic [mpsp_pkg::CSR_W-1:0]   csr_wdata,
   input  wire logic [mpsp_pkg::REQ_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic                              rsp_tuser,
   output logic      [mpsp_pkg::RSP_W-1:0]   rsp_tdata,
   input  wire mpsp_pkg::ctl_cmd_type        cmd,
   output mpsp_pkg::ctl_stat_type            stat
);
   import mpsp_pkg::*;

   localparam int VIDX_W = $clog2(MAX_VOICES);
   localparam int VCNT_W = $clog2(MAX_VOICES + 1);
   localparam int SIZE_W = (ROM_ADDR_BITS + 1 > 21) ? ROM_ADDR_BITS + 1 : 21;
   localparam logic [SIZE_W-1:0] ROM_DEPTH = SIZE_W'(1) << ROM_ADDR_BITS;
   localparam logic [VCNT_W-1:0] NV_BANKED = VCNT_W'(MAX_VOICES);
   localparam logic [VCNT_W-1:0] NV_DISC   = VCNT_W'(8);

   typedef enum logic [3:0] {
      SLOT_LVOL, SLOT_RVOL, SLOT_LOOP_LO, SLOT_LOOP_HI, SLOT_END,
      SLOT_RATE, SLOT_POS_MID, SLOT_POS_HI, SLOT_CTRL
   } slot_type;

   function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
      logic signed [15:0] r;
      if (v > ACC_W'(32767)) r = 16'sh7fff;
      else if (v < -ACC_W'(32768)) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

   function automatic logic signed [18:0] div128(input logic signed [25:0] t);
      logic signed [25:0] adj;
      adj = t + (t[25] ? 26'sd127 : 26'sd0);
      return adj[25:7];
   endfunction

   // Configuration
   logic                 disc_ff;
   logic [4:0]           shift_ff;
   logic [7:0]           mask_ff;
   logic [19:0]          rmul_ff, rdiv_ff;
   logic [20:0]          rsize_ff;
   logic [9:0]           gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         disc_ff  <= 1'b0;
         shift_ff <= '0;
         mask_ff  <= '0;
         rmul_ff  <= 20'd31250;
         rdiv_ff  <= 20'd44100;
         rsize_ff <= '0;
         gain_ff  <= 10'd200;
      end else if (csr_we) begin
         case (csr_index)
            CFG_DISCRETE:   disc_ff  <= csr_wdata[0];
            CFG_BANK_SHIFT: shift_ff <= csr_wdata[4:0];
            CFG_BANK_MASK:  mask_ff  <= csr_wdata[7:0];
            CFG_RATE_MUL:   rmul_ff  <= csr_wdata[19:0];
            CFG_RATE_DIV:   rdiv_ff  <= csr_wdata[19:0];
            CFG_ROM_SIZE:   rsize_ff <= csr_wdata[20:0];
            CFG_MIX_GAIN:   gain_ff  <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // Latched request beat
   logic [7:0]         addr_ff, data_ff, rom_byte_ff;
   logic [19:0]        rom_idx_ff;
   logic signed [15:0] mixl_ff, mixr_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         addr_ff     <= req_tdata[7:0];
         data_ff     <= req_tdata[15:8];
         rom_idx_ff  <= req_tdata[35:16];
         rom_byte_ff <= req_tdata[43:36];
         mixl_ff     <= req_tdata[59:44];
         mixr_ff     <= req_tdata[75:60];
      end
   end

   // Register decode
   logic [VCNT_W-1:0] nvoices;
   logic [3:0]        dec_ch;
   logic              dec_hit;
   slot_type          dec_slot;

   always_comb begin
      nvoices  = disc_ff ? NV_DISC : NV_BANKED;
      dec_ch   = disc_ff ? {1'b0, addr_ff[5:3]} : addr_ff[6:3];
      dec_hit  = 1'b0;
      dec_slot = SLOT_LVOL;
      if (!disc_ff || addr_ff[6]) begin
         case ({addr_ff[7], addr_ff[2:0]})
            4'b0010: begin dec_hit = 1'b1; dec_slot = SLOT_LVOL;    end
            4'b0011: begin dec_hit = 1'b1; dec_slot = SLOT_RVOL;    end
            4'b0100: begin dec_hit = 1'b1; dec_slot = SLOT_LOOP_LO; end
            4'b0101: begin dec_hit = 1'b1; dec_slot = SLOT_LOOP_HI; end
            4'b0110: begin dec_hit = 1'b1; dec_slot = SLOT_END;     end
            4'b0111: begin dec_hit = 1'b1; dec_slot = SLOT_RATE;    end
            4'b1100: begin dec_hit = 1'b1; dec_slot = SLOT_POS_MID; end
            4'b1101: begin dec_hit = 1'b1; dec_slot = SLOT_POS_HI;  end
            4'b1110: begin dec_hit = 1'b1; dec_slot = SLOT_CTRL;    end
            default: ;
         endcase
      end
      if ({1'b0, dec_ch} >= 5'(nvoices)) dec_hit = 1'b0;
   end

   // Voice state
   logic [23:0] pos_ff   [MAX_VOICES];
   logic [19:0] frac_ff  [MAX_VOICES];
   logic [15:0] loop_ff  [MAX_VOICES];
   logic [7:0]  end_ff   [MAX_VOICES];
   logic [7:0]  rate_ff  [MAX_VOICES];
   logic [7:0]  lvol_ff  [MAX_VOICES];
   logic [7:0]  rvol_ff  [MAX_VOICES];
   logic [7:0]  ctrl_ff  [MAX_VOICES];

   logic              tick_mode_ff;
   logic [VCNT_W-1:0] voice_ff;
   logic [VIDX_W-1:0] vsel;
   logic [23:0]       cur_pos;
   logic [19:0]       cur_frac;
   logic [15:0]       cur_loop;
   logic [7:0]        cur_end, cur_rate, cur_lvol, cur_rvol, cur_ctrl, live;

   always_comb begin
      vsel     = tick_mode_ff ? voice_ff[VIDX_W-1:0] : dec_ch[VIDX_W-1:0];
      cur_pos  = pos_ff[vsel];
      cur_frac = frac_ff[vsel];
      cur_loop = loop_ff[vsel];
      cur_end  = end_ff[vsel];
      cur_rate = rate_ff[vsel];
      cur_lvol = lvol_ff[vsel];
      cur_rvol = rvol_ff[vsel];
      cur_ctrl = ctrl_ff[vsel];
      unique case (dec_slot)
         SLOT_LVOL:    live = cur_lvol;
         SLOT_RVOL:    live = cur_rvol;
         SLOT_LOOP_LO: live = cur_loop[7:0];
         SLOT_LOOP_HI: live = cur_loop[15:8];
         SLOT_END:     live = cur_end;
         SLOT_RATE:    live = cur_rate;
         SLOT_POS_MID: live = cur_pos[15:8];
         SLOT_POS_HI:  live = cur_pos[23:16];
         SLOT_CTRL:    live = cur_ctrl;
         default:      live = cur_ctrl;
      endcase
   end

   // Tick arithmetic
   logic [7:0]        gain_sel;
   logic [SIZE_W-1:0] rsize_ext, size_eff, div1;
   logic [DIVD_W-1:0] bank, adr_in;

   always_comb begin
      gain_sel  = (gain_ff > 10'd220) ? (disc_ff ? 8'd200 : 8'd180) : gain_ff[7:0];
      rsize_ext = SIZE_W'(rsize_ff);
      size_eff  = (rsize_ext > ROM_DEPTH) ? ROM_DEPTH : rsize_ext;
      div1      = (rdiv_ff == 20'd0) ? SIZE_W'(1) : SIZE_W'(rdiv_ff);
      bank      = DIVD_W'(cur_ctrl & mask_ff) << shift_ff;
      adr_in    = DIVD_W'(cur_pos[23:8]) + (disc_ff ? '0 : bank);
   end

   logic [DIVD_W-1:0]         adr_ff;
   logic signed [8:0]         sample_ff;
   logic signed [16:0]        pl_ff, pr_ff;
   logic signed [25:0]        tl_ff, tr_ff;
   logic signed [ACC_W-1:0]   accl_ff, accr_ff;
   logic [27:0]               rp_ff;
   logic [28:0]               fsum_ff;
   logic [7:0]                rom_q, reg_q;

   // Divider shared by the wrap modulo and the rate step
   logic [DIVD_W-1:0] quot;
   logic [SIZE_W-1:0] rem;
   logic              div_busy, div_done;

   mpsp_divider #(.DVD_W(DIVD_W), .DVS_W(SIZE_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start_mod | cmd.div_start_rate),
      .dividend  (cmd.div_start_mod ? adr_ff : DIVD_W'(fsum_ff)),
      .divisor   (cmd.div_start_mod ? size_eff : div1),
      .quotient  (quot),
      .remainder (rem),
      .busy      (div_busy),
      .done      (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.addr_calc) adr_ff <= adr_in;
      if (cmd.sample_zero) sample_ff <= '0;
      else if (cmd.sample_load) sample_ff <= $signed({1'b0, rom_q}) - 9'sd128;
      if (cmd.mul_vol) begin
         pl_ff <= sample_ff * $signed({1'b0, cur_lvol[6:0]});
         pr_ff <= sample_ff * $signed({1'b0, cur_rvol[6:0]});
      end
      if (cmd.mul_gain) begin
         tl_ff <= pl_ff * $signed({1'b0, gain_sel});
         tr_ff <= pr_ff * $signed({1'b0, gain_sel});
      end
      if (cmd.tick_init) begin
         accl_ff <= ACC_W'(mixl_ff);
         accr_ff <= ACC_W'(mixr_ff);
      end else if (cmd.acc_add) begin
         accl_ff <= accl_ff + ACC_W'(div128(tl_ff));
         accr_ff <= accr_ff + ACC_W'(div128(tr_ff));
      end
      if (cmd.acc_add) rp_ff <= cur_rate * rmul_ff;
      if (cmd.frac_sum) fsum_ff <= 29'(cur_frac) + 29'(rp_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_mode_ff <= 1'b0;
         voice_ff     <= '0;
      end else begin
         if (cmd.tick_init) begin
            tick_mode_ff <= 1'b1;
            voice_ff     <= '0;
         end else if (cmd.voice_next) begin
            voice_ff <= voice_ff + 1'b1;
         end
         if (cmd.tick_load) tick_mode_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_VOICES; i++) begin
            pos_ff[i]  <= '0;
            frac_ff[i] <= '0;
            loop_ff[i] <= '0;
            end_ff[i]  <= 8'hff;
            rate_ff[i] <= '0;
            lvol_ff[i] <= '0;
            rvol_ff[i] <= '0;
            ctrl_ff[i] <= 8'hff;
         end
      end else begin
         if (cmd.do_write && dec_hit) begin
            unique case (dec_slot)
               SLOT_LVOL:    lvol_ff[vsel] <= data_ff;
               SLOT_RVOL:    rvol_ff[vsel] <= data_ff;
               SLOT_LOOP_LO: loop_ff[vsel] <= {cur_loop[15:8], data_ff};
               SLOT_LOOP_HI: loop_ff[vsel] <= {data_ff, cur_loop[7:0]};
               SLOT_END:     end_ff[vsel]  <= data_ff;
               SLOT_RATE:    rate_ff[vsel] <= data_ff;
               SLOT_POS_MID: pos_ff[vsel]  <= {cur_pos[23:16], data_ff, cur_pos[7:0]};
               SLOT_POS_HI:  pos_ff[vsel]  <= {data_ff, cur_pos[15:0]};
               SLOT_CTRL: begin
                  ctrl_ff[vsel] <= data_ff;
                  if (data_ff[0]) pos_ff[vsel] <= {cur_pos[23:8], 8'h00};
               end
               default: ;
            endcase
         end
         if (cmd.voice_stop) ctrl_ff[vsel] <= cur_ctrl | 8'h01;
         if (cmd.voice_reload) begin
            pos_ff[vsel]  <= {cur_loop, 8'h00};
            frac_ff[vsel] <= '0;
         end
         if (cmd.div_finish) begin
            pos_ff[vsel]  <= cur_pos + quot[23:0];
            frac_ff[vsel] <= rem[19:0];
         end
      end
   end

   // Register RAM, with valid bits standing in for its all-ones reset
   logic [7:0]   vbase, ram_waddr, ram_wdata;
   logic         ram_we, rdv_ff;
   logic [255:0] valid_ff;

   always_comb begin
      vbase     = (disc_ff ? 8'hc0 : 8'h80) + {1'b0, 4'(voice_ff), 3'b000};
      ram_we    = cmd.do_write | cmd.voice_stop | cmd.wr_pos_lo | cmd.wr_pos_hi;
      ram_waddr = addr_ff;
      ram_wdata = data_ff;
      if (cmd.voice_stop) begin
         ram_waddr = vbase + 8'd6;
         ram_wdata = cur_ctrl | 8'h01;
      end else if (cmd.wr_pos_lo) begin
         ram_waddr = vbase + 8'd4;
         ram_wdata = cur_pos[15:8];
      end else if (cmd.wr_pos_hi) begin
         ram_waddr = vbase + 8'd5;
         ram_wdata = cur_pos[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ram_we) begin
         valid_ff[ram_waddr] <= 1'b1;
      end
      if (cmd.rd_issue) rdv_ff <= valid_ff[addr_ff];
   end

   mpsp_ram #(.WIDTH(8), .DEPTH(256)) u_reg_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.rd_issue),
      .raddr (addr_ff),
      .rdata (reg_q)
   );

   // Sample ROM store
   logic [23:0]              rom_idx_ext;
   logic [ROM_ADDR_BITS-1:0] rom_raddr;

   always_comb begin
      rom_idx_ext = 24'(rom_idx_ff);
      rom_raddr   = cmd.rom_rd_mod ? rem[ROM_ADDR_BITS-1:0] : adr_ff[ROM_ADDR_BITS-1:0];
   end

   mpsp_ram #(.WIDTH(8), .DEPTH(1 << ROM_ADDR_BITS)) u_rom (
      .clock (clock),
      .we    (cmd.rom_load),
      .waddr (rom_idx_ext[ROM_ADDR_BITS-1:0]),
      .wdata (rom_byte_ff),
      .re    (cmd.rom_rd_direct | cmd.rom_rd_mod),
      .raddr (rom_raddr),
      .rdata (rom_q)
   );

   // Result register
   logic               rsp_valid_ff, rsp_kind_ff;
   logic [7:0]         rsp_rdata_ff;
   logic signed [15:0] rsp_l_ff, rsp_r_ff;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rd_load || cmd.tick_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rd_load) begin
         rsp_kind_ff  <= KIND_READ;
         rsp_rdata_ff <= dec_hit ? live : (rdv_ff ? reg_q : 8'hff);
         rsp_l_ff     <= '0;
         rsp_r_ff     <= '0;
      end else if (cmd.tick_load) begin
         rsp_kind_ff  <= KIND_STEREO;
         rsp_rdata_ff <= '0;
         rsp_l_ff     <= sat16(accl_ff);
         rsp_r_ff     <= sat16(accr_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {rsp_r_ff, rsp_l_ff, rsp_rdata_ff};

   always_comb begin
      stat.voices_done = voice_ff >= nvoices;
      stat.stopped     = cur_ctrl[0];
      stat.end_hit     = cur_pos[23:16] == (cur_end + 8'd1);
      stat.stop_at_end = cur_ctrl[1];
      stat.in_range    = adr_ff < DIVD_W'(size_eff);
      stat.discrete    = disc_ff;
      stat.size_zero   = rsize_ff == 21'd0;
      stat.div_done    = div_done;
      stat.div_busy    = div_busy;
      stat.out_free    = out_free;
   end
endmodule
`default_nettype wire

// ===== design/mpsp_controller.sv =====
// Controller state machine: sequences writes, reads, ROM loads and the per-voice tick walk.
// Depends on mpsp_pkg.
`default_nettype none
module mpsp_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [1:0]             req_tuser,
   input  wire mpsp_pkg::ctl_stat_type stat,
   output mpsp_pkg::ctl_cmd_type       cmd
);
   import mpsp_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_WRITE, S_ROM, S_RD_ISSUE, S_RD_OUT, S_T_INIT, S_V_CHECK, S_V_ADDR,
      S_V_CMP, S_V_MOD, S_V_FETCH, S_V_MUL_VOL, S_V_MUL_GAIN, S_V_ACC, S_V_FRAC,
      S_V_DIV_START, S_V_DIV, S_V_WR_LO, S_V_WR_HI, S_T_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = state_ff == S_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               unique case (cmd_type'(req_tuser))
                  CMD_WRITE:    state_in = S_WRITE;
                  CMD_READ:     state_in = S_RD_ISSUE;
                  CMD_TICK:     state_in = S_T_INIT;
                  CMD_ROM_LOAD: state_in = S_ROM;
                  default:      state_in = S_IDLE;
               endcase
            end
         end
         S_WRITE: begin
            cmd.do_write = 1'b1;
            state_in     = S_IDLE;
         end
         S_ROM: begin
            cmd.rom_load = 1'b1;
            state_in     = S_IDLE;
         end
         S_RD_ISSUE: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_RD_OUT;
         end
         S_RD_OUT: begin
            if (stat.out_free) begin
               cmd.rd_load = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_T_INIT: begin
            cmd.tick_init = 1'b1;
            state_in      = stat.size_zero ? S_T_OUT : S_V_CHECK;
         end
         S_V_CHECK: begin
            if (stat.voices_done) begin
               state_in = S_T_OUT;
            end else if (stat.stopped) begin
               cmd.voice_next = 1'b1;
            end else if (stat.end_hit && stat.stop_at_end) begin
               cmd.voice_stop = 1'b1;
               cmd.voice_next = 1'b1;
            end else begin
               cmd.voice_reload = stat.end_hit;
               state_in         = S_V_ADDR;
            end
         end
         S_V_ADDR: begin
            cmd.addr_calc = 1'b1;
            state_in      = S_V_CMP;
         end
         S_V_CMP: begin
            if (stat.in_range) begin
               cmd.rom_rd_direct = 1'b1;
               state_in          = S_V_FETCH;
            end else if (stat.discrete) begin
               cmd.sample_zero = 1'b1;
               state_in        = S_V_MUL_VOL;
            end else begin
               cmd.div_start_mod = 1'b1;
               state_in          = S_V_MOD;
            end
         end
         S_V_MOD: begin
            if (stat.div_done) begin
               cmd.rom_rd_mod = 1'b1;
               state_in       = S_V_FETCH;
            end
         end
         S_V_FETCH: begin
            cmd.sample_load = 1'b1;
            state_in        = S_V_MUL_VOL;
         end
         S_V_MUL_VOL: begin
            cmd.mul_vol = 1'b1;
            state_in    = S_V_MUL_GAIN;
         end
         S_V_MUL_GAIN: begin
            cmd.mul_gain = 1'b1;
            state_in     = S_V_ACC;
         end
         S_V_ACC: begin
            cmd.acc_add = 1'b1;
            state_in    = S_V_FRAC;
         end
         S_V_FRAC: begin
            cmd.frac_sum = 1'b1;
            state_in     = S_V_DIV_START;
         end
         S_V_DIV_START: begin
            cmd.div_start_rate = 1'b1;
            state_in           = S_V_DIV;
         end
         S_V_DIV: begin
            if (stat.div_done) begin
               cmd.div_finish = 1'b1;
               state_in       = S_V_WR_LO;
            end
         end
         S_V_WR_LO: begin
            cmd.wr_pos_lo = 1'b1;
            state_in      = S_V_WR_HI;
         end
         S_V_WR_HI: begin
            cmd.wr_pos_hi  = 1'b1;
            cmd.voice_next = 1'b1;
            state_in       = S_V_CHECK;
         end
         S_T_OUT: begin
            if (stat.out_free) begin
               cmd.tick_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ===== tb/sv/tb_multichannel_pcm_sample_player_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multichannel_pcm_sample_player_core.
// Drives request beats from a queue, predicts every result with its own voice model,
// and compares response beats field by field. Depends on mpsp_pkg and the core.
module tb_multichannel_pcm_sample_player_core;
   import mpsp_pkg::*;

   localparam int ROM_DEPTH = 1 << 20;
   localparam int PLAY_ROM  = 64;
   localparam int WD_LIMIT  = 20000;

   typedef struct {
      cmd_type    cmd;
      bit [7:0]   addr;
      bit [7:0]   data;
      bit [19:0]  rom_index;
      bit [7:0]   rom_byte;
      bit [15:0]  mix_l;
      bit [15:0]  mix_r;
      bit         drain;
   } pcm_req_type;

   typedef struct {
      bit         kind;
      bit [7:0]   rd;
      bit [15:0]  left;
      bit [15:0]  right;
   } pcm_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [1:0] req_tuser = '0;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic rsp_tuser;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_we = 0;
   logic [2:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   multichannel_pcm_sample_player_core i_dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   pcm_req_type pending_reqs[$];
   pcm_rsp_type expected_beats[$];
   pcm_req_type cur_req;
   int errors = 0;
   int n_accepted = 0;
   int idle_cnt = 0;
   bit req_fired = 0;

   // Voice model state and configuration.
   bit [7:0]  m_ram[256];
   bit [7:0]  m_rom[ROM_DEPTH];
   bit [23:0] m_pos[16];
   bit [31:0] m_frac[16];
   bit [15:0] m_loop[16];
   bit [7:0]  m_end[16], m_rate[16], m_lvol[16], m_rvol[16], m_ctrl[16];
   bit        c_disc;
   bit [4:0]  c_shift;
   bit [7:0]  c_mask;
   bit [19:0] c_mul, c_div;
   bit [20:0] c_size;
   bit [9:0]  c_gain;

   function automatic int voices();
      return c_disc ? 8 : 16;
   endfunction

   function automatic bit voice_decode(input bit [7:0] a, output int ch, output int slot);
      bit [7:0] b;
      if (c_disc) begin
         ch = (a >> 3) & 7;
         b = a & 8'hc7;
         if (b >= 8'h42 && b <= 8'h47) slot = b - 8'h42;
         else if (b >= 8'hc4 && b <= 8'hc6) slot = 6 + b - 8'hc4;
         else return 0;
      end else begin
         ch = (a >> 3) & 15;
         b = a & 8'h87;
         if (b >= 8'h02 && b <= 8'h07) slot = b - 8'h02;
         else if (b >= 8'h84 && b <= 8'h86) slot = 6 + b - 8'h84;
         else return 0;
      end
      return ch < voices();
   endfunction

   function automatic void model_write(input bit [7:0] a, input bit [7:0] v);
      int ch, slot;
      m_ram[a] = v;
      if (!voice_decode(a, ch, slot)) return;
      case (slot)
         0: m_lvol[ch] = v;
         1: m_rvol[ch] = v;
         2: m_loop[ch][7:0] = v;
         3: m_loop[ch][15:8] = v;
         4: m_end[ch] = v;
         5: m_rate[ch] = v;
         6: m_pos[ch][15:8] = v;
         7: m_pos[ch][23:16] = v;
         default: begin
            m_ctrl[ch] = v;
            if (v[0]) m_pos[ch][7:0] = 0;
         end
      endcase
   endfunction

   function automatic bit [7:0] model_read(input bit [7:0] a);
      int ch, slot;
      if (!voice_decode(a, ch, slot)) return m_ram[a];
      case (slot)
         0: return m_lvol[ch];
         1: return m_rvol[ch];
         2: return m_loop[ch][7:0];
         3: return m_loop[ch][15:8];
         4: return m_end[ch];
         5: return m_rate[ch];
         6: return m_pos[ch][15:8];
         7: return m_pos[ch][23:16];
         default: return m_ctrl[ch];
      endcase
   endfunction

   function automatic void mix_voices(inout int accl, inout int accr);
      longint unsigned size, adr, dv, fr;
      int gain, smp, b;
      size = (c_size < ROM_DEPTH) ? c_size : ROM_DEPTH;
      dv = (c_div != 0) ? c_div : 1;
      gain = c_gain;
      if (size == 0) return;
      if (gain > 220) gain = c_disc ? 200 : 180;
      for (int ch = 0; ch < voices(); ch++) begin
         b = (c_disc ? 8'hc0 : 8'h80) + ch * 8;
         if (m_ctrl[ch][0]) continue;
         if (m_pos[ch][23:16] == 8'(m_end[ch] + 1)) begin
            if (m_ctrl[ch][1]) begin
               m_ctrl[ch][0] = 1;
               m_ram[b + 6] = m_ctrl[ch];
               continue;
            end
            m_pos[ch] = {m_loop[ch], 8'h00};
            m_frac[ch] = 0;
         end
         adr = m_pos[ch] >> 8;
         if (!c_disc) adr += longint'(m_ctrl[ch] & c_mask) << c_shift;
         smp = 0;
         if (adr < size) smp = int'(m_rom[adr]) - 128;
         else if (!c_disc) smp = int'(m_rom[adr % size]) - 128;
         accl += smp * int'(m_lvol[ch][6:0]) * gain / 128;
         accr += smp * int'(m_rvol[ch][6:0]) * gain / 128;
         fr = longint'(m_frac[ch]) + longint'(m_rate[ch]) * c_mul;
         m_frac[ch] = 32'(fr % dv);
         m_pos[ch] = m_pos[ch] + 24'(fr / dv);
         m_ram[b + 4] = m_pos[ch][15:8];
         m_ram[b + 5] = m_pos[ch][23:16];
      end
   endfunction

   function automatic int sat16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic void predict_beat(input pcm_req_type q);
      pcm_rsp_type e;
      int l, r;
      case (q.cmd)
         CMD_WRITE: model_write(q.addr, q.data);
         CMD_ROM_LOAD: m_rom[q.rom_index] = q.rom_byte;
         CMD_READ: begin
            e = '{KIND_READ, model_read(q.addr), 16'd0, 16'd0};
            expected_beats.push_back(e);
         end
         default: begin
            l = $signed(q.mix_l);
            r = $signed(q.mix_r);
            mix_voices(l, r);
            e = '{KIND_STEREO, 8'd0, 16'(sat16(l)), 16'(sat16(r))};
            expected_beats.push_back(e);
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
      errors++;
   endtask

   // Driver: request beats change at the falling edge.
   always @(negedge clock) begin
      bit quiet;
      quiet = n_accepted >= 300 && n_accepted < 420;
      if (!reset && (!req_tvalid || req_fired)) begin
         if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= 22) &&
             (!pending_reqs[0].drain || expected_beats.size() == 0)) begin
            cur_req = pending_reqs.pop_front();
            req_tvalid <= 1;
            req_tuser <= cur_req.cmd;
            req_tdata <= {4'b0, cur_req.mix_r, cur_req.mix_l, cur_req.rom_byte,
                          cur_req.rom_index, cur_req.data, cur_req.addr};
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // Receiver with one long hold-off once the run is under way.
   always @(negedge clock) begin
      static int hold_left = 0;
      static bit hold_done = 0;
      if (!hold_done && n_accepted >= 150) begin
         hold_left = 3000;
         hold_done = 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= (n_accepted >= 300 && n_accepted < 420) || $urandom_range(0, 99) >= 22;
      end
   end

   // Monitor, predictor and watchdog at the rising edge.
   always @(posedge clock) begin
      pcm_rsp_type e;
      bit any;
      any = 0;
      req_fired = 0;
      if (!reset && rsp_tvalid && rsp_tready) begin
         any = 1;
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat", int'(rsp_tdata[31:0]), 0);
         end else begin
            e = expected_beats.pop_front();
            if (rsp_tuser !== e.kind)
               report_mismatch("kind", int'(rsp_tuser), int'(e.kind));
            if (rsp_tdata[7:0] !== e.rd)
               report_mismatch("read_data", int'(rsp_tdata[7:0]), int'(e.rd));
            if (rsp_tdata[23:8] !== e.left)
               report_mismatch("left", int'(rsp_tdata[23:8]), int'(e.left));
            if (rsp_tdata[39:24] !== e.right)
               report_mismatch("right", int'(rsp_tdata[39:24]), int'(e.right));
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         any = 1;
         req_fired = 1;
         n_accepted++;
         predict_beat(cur_req);
      end
      idle_cnt = any ? 0 : idle_cnt + 1;
      if (idle_cnt >= WD_LIMIT && (pending_reqs.size() != 0 || expected_beats.size() != 0
                                   || req_tvalid)) begin
         $display("[multichannel_pcm_sample_player_core] ERROR");
         $finish;
      end
   end

   function automatic pcm_req_type make_req(input cmd_type c, input bit [7:0] a,
                                            input bit [7:0] d);
      pcm_req_type q;
      q = '{c, a, d, 20'($urandom()), 8'($urandom()), 16'($urandom()), 16'($urandom()), 0};
      return q;
   endfunction

   task automatic push(input cmd_type c, input bit [7:0] a, input bit [7:0] d);
      pending_reqs.push_back(make_req(c, a, d));
   endtask

   task automatic push_tick(input bit [15:0] l, input bit [15:0] r);
      pcm_req_type q;
      q = make_req(CMD_TICK, 0, 0);
      q.mix_l = l;
      q.mix_r = r;
      pending_reqs.push_back(q);
   endtask

   function automatic bit [7:0] voice_addr();
      bit [7:0] bases_b[9] = '{8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h84, 8'h85, 8'h86};
      bit [7:0] bases_d[9] = '{8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'hc4, 8'hc5, 8'hc6};
      int k;
      if ($urandom_range(0, 3) == 0) return 8'($urandom());
      k = $urandom_range(0, 8);
      if (c_disc) return bases_d[k] | 8'($urandom_range(0, 7) << 3);
      return bases_b[k] | 8'($urandom_range(0, 15) << 3);
   endfunction

   task automatic push_random(input int n, input bit mid_drain);
      pcm_req_type q;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            q = make_req(CMD_WRITE, voice_addr(), 8'($urandom()));
            if ((q.addr & 8'h07) == 8'h06 && $urandom_range(0, 3) != 0) q.data[0] = 0;
         end else if (r < 55) begin
            q = make_req(CMD_READ, voice_addr(), 0);
         end else if (r < 90) begin
            q = make_req(CMD_TICK, 0, 0);
         end else begin
            q = make_req(CMD_ROM_LOAD, 0, 0);
            if ($urandom_range(0, 9) < 7) q.rom_index = 20'($urandom_range(0, PLAY_ROM - 1));
         end
         q.drain = mid_drain && i == n / 2;
         pending_reqs.push_back(q);
      end
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_tvalid || expected_beats.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_config(input bit disc, input bit [4:0] sh, input bit [7:0] mk,
                             input bit [19:0] mul, input bit [19:0] dv,
                             input bit [20:0] sz, input bit [9:0] g);
      bit [CSR_W-1:0] vals[7];
      vals = '{disc, sh, mk, mul, dv, sz, g};
      c_disc = disc; c_shift = sh; c_mask = mk; c_mul = mul; c_div = dv;
      c_size = sz; c_gain = g;
      for (int i = 0; i < 7; i++) begin
         @(negedge clock);
         csr_we <= 1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
      end
      @(negedge clock);
      csr_we <= 0;
   endtask

   initial begin
      for (int i = 0; i < 256; i++) m_ram[i] = 8'hff;
      for (int i = 0; i < 16; i++) begin
         m_pos[i] = 0; m_frac[i] = 0; m_loop[i] = 0; m_end[i] = 8'hff;
         m_rate[i] = 0; m_lvol[i] = 0; m_rvol[i] = 0; m_ctrl[i] = 8'hff;
      end
      c_disc = 0; c_shift = 0; c_mask = 0; c_mul = 31250; c_div = 44100;
      c_size = 0; c_gain = 200;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Reset settings: no ROM, so ticks pass the incoming mix.
      push(CMD_READ, 8'h00, 0);
      push(CMD_READ, 8'h86, 0);
      push(CMD_WRITE, 8'h12, 8'h5a);
      push(CMD_READ, 8'h12, 0);
      push_tick(16'h7fff, 16'h8000);
      push_tick(16'h0000, 16'hffff);
      wait_idle();

      set_config(0, 0, 0, 31250, 44100, PLAY_ROM, 200);
      for (int i = 0; i < PLAY_ROM; i++) begin
         pending_reqs.push_back(make_req(CMD_ROM_LOAD, 0, 0));
         pending_reqs[$].rom_index = 20'(i);
         if (i == 0) pending_reqs[$].rom_byte = 8'hff;
         if (i == 1) pending_reqs[$].rom_byte = 8'h00;
      end
      push(CMD_WRITE, 8'h02, 8'hff);
      push(CMD_WRITE, 8'h03, 8'h80);
      push(CMD_WRITE, 8'h04, 8'h00);
      push(CMD_WRITE, 8'h05, 8'h00);
      push(CMD_WRITE, 8'h06, 8'h00);
      push(CMD_WRITE, 8'h07, 8'hff);
      push(CMD_WRITE, 8'h86, 8'h00);
      push(CMD_WRITE, 8'h0a, 8'h7f);
      push(CMD_WRITE, 8'h0e, 8'h00);
      push(CMD_WRITE, 8'h0f, 8'hff);
      push(CMD_WRITE, 8'h8e, 8'h02);
      push(CMD_WRITE, 8'h96, 8'h01);
      push_tick(16'h7fff, 16'h8000);
      push_tick(16'h8000, 16'h7fff);
      push_tick(16'h0000, 16'h0000);
      push_tick(16'h1234, 16'hedcb);
      push_tick(16'h7fff, 16'h7fff);
      push(CMD_READ, 8'h84, 0);
      push(CMD_READ, 8'h85, 0);
      push(CMD_READ, 8'h8e, 0);
      push(CMD_READ, 8'h96, 0);
      push_random(180, 0);
      wait_idle();

      set_config(1, 5, 8'h0f, 20'hfffff, 20'hfffff, PLAY_ROM, 1023);
      push_random(180, 1);
      wait_idle();

      set_config(0, 31, 8'hff, 1, 0, PLAY_ROM, 221);
      push_random(90, 0);
      wait_idle();
      set_config(0, 23, 8'h38, 20'hfffff, 3, PLAY_ROM, 0);
      push_random(90, 0);
      wait_idle();

      // Largest ROM sizes, with every voice stopped so no unloaded byte is fetched.
      set_config(0, 0, 0, 0, 1, 21'h1fffff, 220);
      for (int ch = 0; ch < 16; ch++) push(CMD_WRITE, 8'h86 | 8'(ch << 3), 8'hff);
      push_tick(16'h4000, 16'hc000);
      push(CMD_READ, 8'h84, 0);
      wait_idle();
      set_config(1, 0, 0, 0, 1, ROM_DEPTH, 220);
      push_tick(16'h7fff, 16'h8000);
      push(CMD_READ, 8'hc6, 0);
      wait_idle();
      repeat (200) @(posedge clock);

      if (errors == 0) begin
         $display("[multichannel_pcm_sample_player_core] OK");
      end else begin
         $display("[multichannel_pcm_sample_player_core] ERROR");
      end
      $finish;
   end
endmodule
